// ===== hw/rtl/sha1md_pkg.sv =====
// Shared types and constants for the SHA-1 message digest block.
`default_nettype none

package sha1md_pkg;

    // Round constants
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    // Initial chaining value, entry 0 is H0
    localparam logic [4:0][31:0] H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    // Padding constants
    localparam logic [7:0] PAD_BYTE      = 8'h80;
    localparam logic [5:0] LEN_FIELD_POS = 6'd56;  // byte 56 of a block
    localparam logic [5:0] LAST_POS      = 6'd63;
    localparam logic [6:0] LAST_ROUND    = 7'd79;
    localparam logic [2:0] LAST_WORD     = 3'd4;
    localparam logic [2:0] LAST_LEN_BYTE = 3'd7;

    // Stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    // Item queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // One queued input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } item_t;

    // Back-end control states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    // Padding phases
    typedef enum logic [2:0] {
        PAD_MARK = 3'b001,
        PAD_ZERO = 3'b010,
        PAD_LEN  = 3'b100
    } pad_phase_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sha1md_front.sv =====
// Input side: accepts items, drops empty ones, queues the rest for the engine.
`default_nettype none

module sha1md_front
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [sha1md_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // data_byte
    input  wire logic                               s_axis_tuser,  // byte_present
    input  wire logic                               s_axis_tlast,  // end_of_message
    output logic                                    q_valid,
    output sha1md_pkg::item_t                       q_item,
    input  wire logic                               q_pop
);

    sha1md_pkg::item_t                     mem [sha1md_pkg::QUEUE_DEPTH];
    logic [sha1md_pkg::QUEUE_AW-1:0]       wr_ptr_reg;
    logic [sha1md_pkg::QUEUE_AW-1:0]       rd_ptr_reg;
    logic [sha1md_pkg::QUEUE_CW-1:0]       count_reg;
    logic [sha1md_pkg::QUEUE_CW-1:0]       count_next;
    logic                                  in_xfer;
    logic                                  push;
    logic                                  pop;

    // Items with neither flag change nothing and are not queued
    assign s_axis_tready = (count_reg != sha1md_pkg::QUEUE_CW'(sha1md_pkg::QUEUE_DEPTH));
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign push          = in_xfer && (s_axis_tuser || s_axis_tlast);
    assign q_valid       = (count_reg != '0);
    assign pop           = q_pop && q_valid;
    assign q_item        = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= '{data_byte:      s_axis_tdata,
                                 byte_present:   s_axis_tuser,
                                 end_of_message: s_axis_tlast};
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sha1md_core.sv =====
// Engine: packs bytes, pads, runs the 80-round compression and emits the digest.
`default_nettype none

module sha1md_core
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                q_valid,
    input  wire sha1md_pkg::item_t                   q_item,
    output logic                                     q_pop,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [sha1md_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,  // digest_word, word_index
    output logic                                     m_axis_tlast   // last_word
);

    sha1md_pkg::state_t     state_reg, state_next;
    sha1md_pkg::pad_phase_t pad_reg, pad_next;
    logic [4:0][31:0]       chain_reg, chain_next;
    logic [4:0][31:0]       vars_reg, vars_next;
    logic [511:0]           blk_reg, blk_next;
    logic [63:0]            bits_reg, bits_next;
    logic [63:0]            len_reg, len_next;
    logic [2:0]             len_cnt_reg, len_cnt_next;
    logic [6:0]             rnd_reg, rnd_next;
    logic [2:0]             out_idx_reg, out_idx_next;
    logic                   fin_reg, fin_next;
    logic                   last_reg, last_next;

    logic                   push_en;
    logic [7:0]             push_byte;
    logic [5:0]             pos;
    logic [31:0]            w0, w2, w8, w13, sched_x, sched;
    logic [31:0]            ra, rb, rc, rd, re, f, kc, tmp;

    assign pos = bits_reg[8:3];

    // Message schedule taps on the 16-word window
    assign w0      = blk_reg[511:480];
    assign w2      = blk_reg[447:416];
    assign w8      = blk_reg[255:224];
    assign w13     = blk_reg[95:64];
    assign sched_x = w13 ^ w8 ^ w2 ^ w0;
    assign sched   = {sched_x[30:0], sched_x[31]};

    // Round function
    assign ra = vars_reg[0];
    assign rb = vars_reg[1];
    assign rc = vars_reg[2];
    assign rd = vars_reg[3];
    assign re = vars_reg[4];

    always_comb
    begin
        if (rnd_reg < 7'd20)
        begin
            f  = (rb & rc) | (~rb & rd);
            kc = sha1md_pkg::K0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f  = rb ^ rc ^ rd;
            kc = sha1md_pkg::K1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f  = (rb & rc) | (rb & rd) | (rc & rd);
            kc = sha1md_pkg::K2;
        end
        else
        begin
            f  = rb ^ rc ^ rd;
            kc = sha1md_pkg::K3;
        end
    end

    assign tmp = {ra[26:0], ra[31:27]} + f + re + kc + w0;

    // Queue pops only while waiting for input
    assign q_pop = (state_reg == sha1md_pkg::ST_IDLE) && q_valid;

    // Digest output straight from the chaining value
    assign m_axis_tvalid = (state_reg == sha1md_pkg::ST_OUT);
    assign m_axis_tlast  = (out_idx_reg == sha1md_pkg::LAST_WORD);
    assign m_axis_tdata  = {5'b0, out_idx_reg, chain_reg[out_idx_reg]};

    // Next-state logic
    always_comb
    begin
        state_next   = state_reg;
        pad_next     = pad_reg;
        chain_next   = chain_reg;
        vars_next    = vars_reg;
        blk_next     = blk_reg;
        bits_next    = bits_reg;
        len_next     = len_reg;
        len_cnt_next = len_cnt_reg;
        rnd_next     = rnd_reg;
        out_idx_next = out_idx_reg;
        fin_next     = fin_reg;
        last_next    = last_reg;
        push_en      = 1'b0;
        push_byte    = 8'h00;

        case (state_reg)
            sha1md_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    push_en   = q_item.byte_present;
                    push_byte = q_item.data_byte;
                    if (q_item.end_of_message)
                    begin
                        fin_next   = 1'b1;
                        pad_next   = sha1md_pkg::PAD_MARK;
                        state_next = sha1md_pkg::ST_PAD;
                        len_next   = q_item.byte_present ? (bits_reg + 64'd8) : bits_reg;
                    end
                end
            end
            sha1md_pkg::ST_PAD:
            begin
                case (pad_reg)
                    sha1md_pkg::PAD_MARK:
                    begin
                        push_en   = 1'b1;
                        push_byte = sha1md_pkg::PAD_BYTE;
                        pad_next  = sha1md_pkg::PAD_ZERO;
                    end
                    sha1md_pkg::PAD_ZERO:
                    begin
                        if (pos == sha1md_pkg::LEN_FIELD_POS)
                        begin
                            pad_next     = sha1md_pkg::PAD_LEN;
                            len_cnt_next = '0;
                        end
                        else
                        begin
                            push_en = 1'b1;
                        end
                    end
                    sha1md_pkg::PAD_LEN:
                    begin
                        push_en      = 1'b1;
                        push_byte    = len_reg[63:56];
                        len_next     = {len_reg[55:0], 8'h00};
                        len_cnt_next = len_cnt_reg + 1'b1;
                        if (len_cnt_reg == sha1md_pkg::LAST_LEN_BYTE)
                        begin
                            last_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        pad_next = sha1md_pkg::PAD_MARK;
                    end
                endcase
            end
            sha1md_pkg::ST_ROUND:
            begin
                vars_next = {rd, rc, {rb[1:0], rb[31:2]}, ra, tmp};
                blk_next  = {blk_reg[479:0], sched};
                rnd_next  = rnd_reg + 1'b1;
                if (rnd_reg == sha1md_pkg::LAST_ROUND)
                begin
                    rnd_next   = '0;
                    state_next = sha1md_pkg::ST_ADD;
                end
            end
            sha1md_pkg::ST_ADD:
            begin
                for (int k = 0; k < 5; k++)
                begin
                    chain_next[k] = chain_reg[k] + vars_reg[k];
                end
                out_idx_next = '0;
                if (last_reg)
                begin
                    state_next = sha1md_pkg::ST_OUT;
                end
                else if (fin_reg)
                begin
                    state_next = sha1md_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha1md_pkg::ST_IDLE;
                end
            end
            sha1md_pkg::ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    if (out_idx_reg == sha1md_pkg::LAST_WORD)
                    begin
                        chain_next = sha1md_pkg::H_INIT;
                        bits_next  = '0;
                        fin_next   = 1'b0;
                        last_next  = 1'b0;
                        state_next = sha1md_pkg::ST_IDLE;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = sha1md_pkg::ST_IDLE;
            end
        endcase

        // Byte append; a full block starts the compression
        if (push_en)
        begin
            blk_next  = {blk_reg[503:0], push_byte};
            bits_next = bits_reg + 64'd8;
            if (pos == sha1md_pkg::LAST_POS)
            begin
                vars_next  = chain_reg;
                rnd_next   = '0;
                state_next = sha1md_pkg::ST_ROUND;
            end
        end
    end

    // Control and reset-defined state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sha1md_pkg::ST_IDLE;
            pad_reg     <= sha1md_pkg::PAD_MARK;
            chain_reg   <= sha1md_pkg::H_INIT;
            bits_reg    <= '0;
            len_cnt_reg <= '0;
            rnd_reg     <= '0;
            out_idx_reg <= '0;
            fin_reg     <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pad_reg     <= pad_next;
            chain_reg   <= chain_next;
            bits_reg    <= bits_next;
            len_cnt_reg <= len_cnt_next;
            rnd_reg     <= rnd_next;
            out_idx_reg <= out_idx_next;
            fin_reg     <= fin_next;
            last_reg    <= last_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        blk_reg  <= blk_next;
        vars_reg <= vars_next;
        len_reg  <= len_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sha1_message_digest_top.sv =====
// Top level of the SHA-1 message digest block.
//
// Channel   Dir  Fields (low bit up)                       Transfer
// s_axis    in   tdata: data_byte[7:0]; tuser: byte_present; tlast: end_of_message
//                                                            tvalid && tready
// m_axis    out  tdata: digest_word[31:0], word_index[34:32], zero[39:35];
//                tlast: last_word                            tvalid && tready
//
// The engine appends message bytes while idle; each full 64-byte block then runs
// 80 rounds on the shared round unit plus the chaining add. End of message:
// padding bytes, one or two more compressions, then five output words. A
// four-entry item queue takes input while the engine compresses or the output
// stalls. Asynchronous active-low reset; no clearing pass is needed.
`default_nettype none

module sha1_message_digest_top
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [sha1md_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // data_byte
    input  wire logic                                s_axis_tuser,  // byte_present
    input  wire logic                                s_axis_tlast,  // end_of_message
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [sha1md_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,  // digest_word, word_index
    output logic                                     m_axis_tlast   // last_word
);

    logic              q_valid;
    logic              q_pop;
    sha1md_pkg::item_t q_item;

    sha1md_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    sha1md_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/sha1md_checker.sv =====
// Port-level checks on the digest output stream, bound to the top level.
`default_nettype none

module sha1md_checker
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic [sha1md_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  wire logic                                m_axis_tlast
);

    // Stalled transfer keeps valid and payload
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    // Last word flag matches the word index
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd4)))
        else $error("tlast does not match word index");

    // Digest words follow each other with rising index
    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tdata[34:32] == 3'($past(m_axis_tdata[34:32]) + 3'd1)))
        else $error("digest word sequence broken");

    // A new digest starts at word zero
    a_idx_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> (m_axis_tdata[34:32] == 3'd0))
        else $error("digest does not start at word zero");

endmodule

bind sha1_message_digest_top sha1md_checker u_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
